// ===== hw/rtl/fkbh_pkg.sv =====
// ----------------------------------------------------------------------------
// fkbh_pkg
// Shared types, codes and the fold hash for the folded-key bucket hash table.
// ----------------------------------------------------------------------------
package fkbh_pkg;

   localparam int TABLE_BUCKETS        = 32;
   localparam int HASH_KEY_BITS        = 8;
   localparam int HASH_HALF            = HASH_KEY_BITS / 2;
   localparam int BUCKET_W             = 5;
   localparam int KEY_W                = 16;
   localparam int VALUE_W              = 32;
   localparam int DEF_SLOTS_PER_BUCKET = 4;
   localparam int QUEUE_DEPTH          = 2;
   localparam int QUEUE_PTR_W          = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W          = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_SEARCH = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_DUPLICATE = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [1:0] STATUS_FULL      = 2'd3;

   typedef struct packed {
      logic [1:0]                 cmd;
      logic [KEY_W-1:0]           key;
      logic signed [VALUE_W-1:0]  value;
   } req_type;

   typedef struct packed {
      logic [1:0]                 status;
      logic [BUCKET_W-1:0]        bucket;
      logic signed [VALUE_W-1:0]  found_value;
   } rsp_type;

   // one classified request waiting for the back end
   typedef struct packed {
      req_type                    req;
      logic [BUCKET_W-1:0]        bucket;
   } work_type;

   // high nibble xor low nibble of the low key byte, times two
   function automatic logic [BUCKET_W-1:0] fold_bucket(input logic [KEY_W-1:0] key);
      logic [HASH_HALF-1:0] folded;
      folded = key[HASH_HALF-1:0] ^ key[2*HASH_HALF-1:HASH_HALF];
      return {folded, 1'b0};
   endfunction

endpackage

// ===== hw/rtl/fkbh_front.sv =====
// ----------------------------------------------------------------------------
// fkbh_front
// Accepts requests, hashes the key to its bucket and pushes the word on.
// ----------------------------------------------------------------------------
module fkbh_front
   import fkbh_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  req_type  req_data,
   input  logic     q_full,
   output logic     busy,
   output logic     push,
   output work_type push_data
);

   logic busy_ff;
   logic busy_in;

   // raise busy from a registered copy of reset so nothing is taken before the queue is clean
   always_comb begin
      busy_in = reset;
   end

   always_ff @(posedge clock) begin
      busy_ff <= busy_in;
   end

   assign busy = q_full | busy_ff;
   assign push = start & ~busy;

   always_comb begin
      push_data.req    = req_data;
      push_data.bucket = fold_bucket(req_data.key);
   end

endmodule

// ===== hw/rtl/fkbh_queue.sv =====
// ----------------------------------------------------------------------------
// fkbh_queue
// Short queue between the front and back ends of the hash table.
// ----------------------------------------------------------------------------
module fkbh_queue
   import fkbh_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  work_type push_data,
   input  logic     pop,
   output work_type pop_data,
   output logic     full,
   output logic     empty
);

   work_type                 entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                     do_push, do_pop;

   assign full     = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/fkbh_back.sv =====
// ----------------------------------------------------------------------------
// fkbh_back
// Reads one bucket row, compares all slots at once, writes back and answers.
// ----------------------------------------------------------------------------
module fkbh_back
   import fkbh_pkg::*;
#(
   parameter int SLOTS_PER_BUCKET = DEF_SLOTS_PER_BUCKET
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     q_empty,
   input  work_type q_data,
   output logic     pop,
   output logic     rsp_strobe,
   output rsp_type  rsp_data
);

   localparam int SLOT_W  = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
   localparam int KROW_W  = SLOTS_PER_BUCKET * KEY_W;
   localparam int VROW_W  = SLOTS_PER_BUCKET * VALUE_W;

   localparam logic ST_FETCH = 1'b0;
   localparam logic ST_EXEC  = 1'b1;

   logic                          state_ff, state_in;
   work_type                      work_ff;
   logic [SLOTS_PER_BUCKET-1:0]   valid_ff [TABLE_BUCKETS];
   logic [KROW_W-1:0]             key_mem  [TABLE_BUCKETS];
   logic [VROW_W-1:0]             val_mem  [TABLE_BUCKETS];
   logic [KROW_W-1:0]             key_row_ff, key_row_in;
   logic [VROW_W-1:0]             val_row_ff, val_row_in;
   logic                          rsp_strobe_ff, rsp_strobe_in;
   rsp_type                       rsp_data_ff, rsp_data_in;

   logic [SLOTS_PER_BUCKET-1:0]   row_valid;
   logic [SLOTS_PER_BUCKET-1:0]   match;
   logic                          hit_found, free_found;
   logic [SLOT_W-1:0]             hit_idx, free_idx;
   logic                          row_we, set_valid, clr_valid;

   assign pop = (state_ff == ST_FETCH) & ~q_empty;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_FETCH: if (!q_empty) state_in = ST_EXEC;
         ST_EXEC:  state_in = ST_FETCH;
         default:  state_in = ST_FETCH;
      endcase
   end

   // slot compare and lowest-index selection over the bucket row
   always_comb begin
      row_valid  = valid_ff[work_ff.bucket];
      hit_found  = 1'b0;
      free_found = 1'b0;
      hit_idx    = '0;
      free_idx   = '0;
      for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
         match[s] = row_valid[s] && (key_row_ff[s*KEY_W +: KEY_W] == work_ff.req.key);
         if (!hit_found && match[s]) begin
            hit_found = 1'b1;
            hit_idx   = SLOT_W'(s);
         end
         if (!free_found && !row_valid[s]) begin
            free_found = 1'b1;
            free_idx   = SLOT_W'(s);
         end
      end
   end

   always_comb begin
      row_we                  = 1'b0;
      set_valid               = 1'b0;
      clr_valid               = 1'b0;
      key_row_in              = key_row_ff;
      val_row_in              = val_row_ff;
      rsp_strobe_in           = (state_ff == ST_EXEC);
      rsp_data_in.status      = STATUS_NOT_FOUND;
      rsp_data_in.bucket      = work_ff.bucket;
      rsp_data_in.found_value = '0;
      key_row_in[free_idx*KEY_W +: KEY_W]     = work_ff.req.key;
      val_row_in[free_idx*VALUE_W +: VALUE_W] = work_ff.req.value;
      unique case (work_ff.req.cmd)
         CMD_INSERT: begin
            if (hit_found) begin
               rsp_data_in.status = STATUS_DUPLICATE;
            end else if (!free_found) begin
               rsp_data_in.status = STATUS_FULL;
            end else begin
               rsp_data_in.status = STATUS_OK;
               row_we             = 1'b1;
               set_valid          = 1'b1;
            end
         end
         CMD_SEARCH: begin
            if (hit_found) begin
               rsp_data_in.status      = STATUS_OK;
               rsp_data_in.found_value = val_row_ff[hit_idx*VALUE_W +: VALUE_W];
            end
         end
         CMD_REMOVE: begin
            if (hit_found) begin
               rsp_data_in.status = STATUS_OK;
               clr_valid          = 1'b1;
            end
         end
         default: begin
            rsp_data_in.status = STATUS_NOT_FOUND;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_FETCH;
         rsp_strobe_ff <= 1'b0;
         for (int b = 0; b < TABLE_BUCKETS; b++) begin
            valid_ff[b] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (state_ff == ST_EXEC && set_valid) begin
            valid_ff[work_ff.bucket][free_idx] <= 1'b1;
         end
         if (state_ff == ST_EXEC && clr_valid) begin
            valid_ff[work_ff.bucket][hit_idx] <= 1'b0;
         end
      end
   end

   // bucket row memories: read in fetch, written in exec
   always_ff @(posedge clock) begin
      if (pop) begin
         work_ff    <= q_data;
         key_row_ff <= key_mem[q_data.bucket];
         val_row_ff <= val_mem[q_data.bucket];
      end
      if (state_ff == ST_EXEC && row_we) begin
         key_mem[work_ff.bucket] <= key_row_in;
         val_mem[work_ff.bucket] <= val_row_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

// ===== hw/rtl/folded_key_bucket_hash_table.sv =====
// ----------------------------------------------------------------------------
// folded_key_bucket_hash_table
// Key-value map with a folded-byte hash and a fixed number of slots per bucket.
// ----------------------------------------------------------------------------
// usage:
//   a request word (cmd, key, value) is taken on a rising edge with start high
//   and busy low. cmd selects insert, search or remove.
//   every request gives exactly one response word on rsp_data, shown for one
//   cycle with rsp_strobe high: status, the key's bucket, and the stored
//   value on a successful search (zero otherwise).
//   from acceptance a request passes through the queue, then the back end's
//   fetch state, which reads the bucket row, and its exec state, which
//   compares all slots, writes back and registers the response. the back end
//   takes the next request only after it has answered the last one.
//   a two-word queue sits between the front end and the back end; busy rises
//   while it is full.
//   reset empties the table at once (per-slot valid flops) and drops any
//   queued request; busy is driven high from a registered copy of reset.
//   the receiver cannot stall: each response must be taken when it appears.
// ----------------------------------------------------------------------------
module folded_key_bucket_hash_table
   import fkbh_pkg::*;
#(
   parameter int SLOTS_PER_BUCKET = DEF_SLOTS_PER_BUCKET
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   logic     push, pop, q_full, q_empty;
   work_type push_data, pop_data;

   fkbh_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .q_full    (q_full),
      .busy      (busy),
      .push      (push),
      .push_data (push_data)
   );

   fkbh_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   fkbh_back #(
      .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_data     (pop_data),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
